/* src/alte_pkg.sv */
// Shared types and codes for the array list table engine.
`default_nettype none

package alte_pkg;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_INSERT     = 3'd1,
    OP_DEL_SHIFT  = 3'd2,
    OP_DEL_SWAP   = 3'd3,
    OP_FIND_EQ    = 3'd4,
    OP_FIND_RANGE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FOUND_W  = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CAP_W    = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage

`default_nettype wire

/* src/alte_if.sv */
// Request and result channel interfaces for the array list table engine.
`default_nettype none

interface alte_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [alte_pkg::OP_W-1:0]        operation;
  logic        [alte_pkg::POS_W-1:0]       position;
  logic signed [alte_pkg::VAL_W-1:0]       value;
  logic signed [alte_pkg::VAL_W-1:0]       range_low;
  logic signed [alte_pkg::VAL_W-1:0]       range_high;

  modport source (output valid, operation, position, value, range_low, range_high,
                  input ready);
  modport sink   (input valid, operation, position, value, range_low, range_high,
                  output ready);
endinterface

interface alte_out_if;
  logic                                valid;
  logic                                ready;
  logic [alte_pkg::STATUS_W-1:0]       status;
  logic [alte_pkg::FOUND_W-1:0]        found_index;
  logic [alte_pkg::COUNT_W-1:0]        entry_count;

  modport source (output valid, status, found_index, entry_count, input ready);
  modport sink   (input valid, status, found_index, entry_count, output ready);
endinterface

`default_nettype wire

/* src/array_list_table_engine_unit.sv */
// Top level of the array list table engine: list memory, sequencer and result register.
// A packed list of up to MAX_ENTRIES signed Q16.16 words kept in one entry memory
// (one write and one registered read per cycle) with a used-entry count. Each request
// gives one result. Append, bad-position and full errors, unused codes, insert at the
// end, shifting delete of the last entry and searches of an empty list go from
// acceptance straight to S_DONE. Shifting insert at a position below the count,
// shifting delete below the last entry, swap delete and searches walk entries in
// S_WALK, then S_FLUSH (insert also S_FINAL); a search ends at its first match. Every moved or
// compared entry passes the memory read port once, one entry per cycle. A new request
// is taken as soon as the previous one has reached the result register, even while
// that result still waits to be taken. The capacity register resets to 64; the user
// writes it through cfg_we/cfg_wdata only while idle, which the block does not enforce.
`default_nettype none

module array_list_table_engine_unit #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [alte_pkg::CAP_W-1:0]        cfg_wdata,
  alte_in_if.sink                          in_ch,
  alte_out_if.source                       out_ch
);

  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CMPW = (CW > alte_pkg::POS_W) ? CW : alte_pkg::POS_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_FLUSH = 5'b00100,
    S_FINAL = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [alte_pkg::CAP_W-1:0]      cap_r;
  logic [alte_pkg::OP_W-1:0]       op_r, op_nxt;
  logic [AW-1:0]                   pos_r, pos_nxt;
  logic signed [31:0]              val_r, val_nxt;
  logic signed [31:0]              lo_r, lo_nxt;
  logic signed [31:0]              hi_r, hi_nxt;
  logic [AW-1:0]                   cur_r, cur_nxt;
  logic [AW-1:0]                   end_r, end_nxt;
  logic                            up_r, up_nxt;
  logic                            pipe_v_r, pipe_v_nxt;
  logic [AW-1:0]                   pipe_addr_r, pipe_addr_nxt;
  alte_pkg::status_t               status_r, status_nxt;
  logic [AW-1:0]                   found_r, found_nxt;
  logic signed [31:0]              rdata_r;
  logic                            out_valid_r, out_valid_nxt;
  alte_pkg::status_t               out_status_r;
  logic [alte_pkg::FOUND_W-1:0]    out_found_r;
  logic [alte_pkg::COUNT_W-1:0]    out_count_r;
  logic                            out_load;

  logic [31:0]                     mem [MAX_ENTRIES];
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [31:0]                     mem_wdata;
  logic                            mem_re;

  logic                            in_acc;
  logic [CMPW-1:0]                 pos_x, n_x, cap_x, max_x, nm1_x;
  logic [CW-1:0]                   cnt_m1;
  logic [AW-1:0]                   pos_a, nm1_a;
  logic                            full;
  logic                            is_search;
  logic                            hit;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign pos_x  = CMPW'(in_ch.position);
  assign n_x    = CMPW'(count_r);
  assign cap_x  = CMPW'(cap_r);
  assign max_x  = CMPW'(MAX_ENTRIES);
  assign cnt_m1 = count_r - CW'(1);
  assign nm1_x  = CMPW'(cnt_m1);
  assign nm1_a  = cnt_m1[AW-1:0];
  assign pos_a  = pos_x[AW-1:0];
  assign full   = (n_x >= cap_x) || (n_x >= max_x);

  assign is_search = (op_r == alte_pkg::OP_FIND_EQ) || (op_r == alte_pkg::OP_FIND_RANGE);
  assign hit = pipe_v_r && is_search &&
               ((op_r == alte_pkg::OP_FIND_EQ) ? (rdata_r == val_r)
                                               : ((rdata_r >= lo_r) && (rdata_r <= hi_r)));
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    end_nxt       = end_r;
    up_nxt        = up_r;
    pipe_v_nxt    = 1'b0;
    pipe_addr_nxt = pipe_addr_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    mem_we        = 1'b0;
    mem_waddr     = pipe_addr_r;
    mem_wdata     = rdata_r;
    mem_re        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    // shift data trailing one read behind
    if (pipe_v_r && !is_search) begin
      mem_we = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_ch.operation;
          pos_nxt    = pos_a;
          val_nxt    = in_ch.value;
          lo_nxt     = in_ch.range_low;
          hi_nxt     = in_ch.range_high;
          status_nxt = alte_pkg::ST_OK;
          found_nxt  = '0;
          state_nxt  = S_DONE;
          unique case (in_ch.operation)
            alte_pkg::OP_APPEND: begin
              if (full) begin
                status_nxt = alte_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_ch.value;
                count_nxt = count_r + CW'(1);
              end
            end
            alte_pkg::OP_INSERT: begin
              if (pos_x > n_x) begin
                status_nxt = alte_pkg::ST_BADPOS;
              end else if (full) begin
                status_nxt = alte_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
                if (pos_x == n_x) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_r[AW-1:0];
                  mem_wdata = in_ch.value;
                end else begin
                  cur_nxt   = nm1_a;
                  end_nxt   = pos_a;
                  up_nxt    = 1'b0;
                  state_nxt = S_WALK;
                end
              end
            end
            alte_pkg::OP_DEL_SHIFT: begin
              if (pos_x >= n_x) begin
                status_nxt = alte_pkg::ST_BADPOS;
              end else begin
                count_nxt = cnt_m1;
                if (pos_x != nm1_x) begin
                  cur_nxt   = pos_a + AW'(1);
                  end_nxt   = nm1_a;
                  up_nxt    = 1'b1;
                  state_nxt = S_WALK;
                end
              end
            end
            alte_pkg::OP_DEL_SWAP: begin
              if (pos_x >= n_x) begin
                status_nxt = alte_pkg::ST_BADPOS;
              end else begin
                count_nxt = cnt_m1;
                cur_nxt   = nm1_a;
                end_nxt   = nm1_a;
                up_nxt    = 1'b1;
                state_nxt = S_WALK;
              end
            end
            alte_pkg::OP_FIND_EQ, alte_pkg::OP_FIND_RANGE: begin
              status_nxt = alte_pkg::ST_NOTFOUND;
              if (count_r != '0) begin
                cur_nxt   = '0;
                end_nxt   = nm1_a;
                up_nxt    = 1'b1;
                state_nxt = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        mem_re     = 1'b1;
        pipe_v_nxt = 1'b1;
        cur_nxt    = up_r ? (cur_r + AW'(1)) : (cur_r - AW'(1));
        unique case (op_r)
          alte_pkg::OP_INSERT:    pipe_addr_nxt = cur_r + AW'(1);
          alte_pkg::OP_DEL_SHIFT: pipe_addr_nxt = cur_r - AW'(1);
          alte_pkg::OP_DEL_SWAP:  pipe_addr_nxt = pos_r;
          default:                pipe_addr_nxt = cur_r;
        endcase
        if (hit) begin
          status_nxt = alte_pkg::ST_OK;
          found_nxt  = pipe_addr_r;
          pipe_v_nxt = 1'b0;
          state_nxt  = S_DONE;
        end else if (cur_r == end_r) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (hit) begin
          status_nxt = alte_pkg::ST_OK;
          found_nxt  = pipe_addr_r;
        end
        state_nxt = (op_r == alte_pkg::OP_INSERT) ? S_FINAL : S_DONE;
      end
      S_FINAL: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= alte_pkg::CAP_RESET;
      pipe_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pipe_v_r    <= pipe_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    cur_r       <= cur_nxt;
    end_r       <= end_nxt;
    up_r        <= up_nxt;
    pipe_addr_r <= pipe_addr_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_found_r  <= alte_pkg::FOUND_W'(found_r);
      out_count_r  <= alte_pkg::COUNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[cur_r];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_found_r;
  assign out_ch.entry_count = out_count_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted request did not start work");

  a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("finished request did not reach result register");

  a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(count_r))
    else $error("entry count changed without a request");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_re && mem_we) |-> (mem_waddr != cur_r))
    else $error("shift write and read hit the same entry");

endmodule

`default_nettype wire
